@@ hdl/rgbpk_pkg.sv @@
// Shared constants and types for the RGB888 to RGB555 packetiser.
`timescale 1ns / 1ps
package rgbpk_pkg;

  // Pixels per memory-write packet (1 to 128).
  localparam int PIXELS = 128;

  // Depth of the pending-pixel queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Record headers.
  localparam logic [7:0] HDR_DATA    = 8'h18;
  localparam logic [7:0] HDR_ADDRESS = 8'h16;
  localparam logic [7:0] HDR_LENGTH  = 8'h17;
  localparam logic [7:0] REC_SIZE    = 8'h02;
  localparam logic [7:0] DATA_COUNT  = 8'(2 * PIXELS - 1);
  localparam logic [7:0] LEN_COUNT   = 8'(PIXELS - 1);

  // Colour byte phases.
  localparam logic [1:0] PH_RED   = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;

  // Positions within one output run.
  localparam logic [3:0] ST_DATA_HDR  = 4'd0;
  localparam logic [3:0] ST_DATA_CNT  = 4'd1;
  localparam logic [3:0] ST_PIX_HI    = 4'd2;
  localparam logic [3:0] ST_PIX_LO    = 4'd3;
  localparam logic [3:0] ST_ADDR_HDR  = 4'd4;
  localparam logic [3:0] ST_ADDR_SIZE = 4'd5;
  localparam logic [3:0] ST_ADDR_B2   = 4'd6;
  localparam logic [3:0] ST_ADDR_B1   = 4'd7;
  localparam logic [3:0] ST_ADDR_B0   = 4'd8;
  localparam logic [3:0] ST_LEN_HDR   = 4'd9;
  localparam logic [3:0] ST_LEN_SIZE  = 4'd10;
  localparam logic [3:0] ST_LEN_B2    = 4'd11;
  localparam logic [3:0] ST_LEN_B1    = 4'd12;
  localparam logic [3:0] ST_LEN_B0    = 4'd13;

  // One queued pixel and what surrounds it.
  typedef struct packed {
    logic [7:0]  pix_hi;
    logic [7:0]  pix_lo;
    logic        opens;
    logic        closes;
    logic [23:0] address;
  } pix_entry_t;

endpackage

@@ hdl/rgb888_to_rgb555_packetizer_unit.sv @@
// Top level: RGB888 byte stream to RGB555 memory-write packets.
`timescale 1ns / 1ps
// Latency: when the pixel queue is empty, a blue byte's first result byte is offered the cycle after it is accepted.
// Throughput: one input byte per cycle; output one byte per cycle while out_stall is low,
//   2 to 12 per pixel, drained from a 4-entry pixel queue; input stalls only while it is full.
// Reset (rst, synchronous, active high) clears phase, pixel index, colour bits, address,
//   queue pointers and the run counter; queue payload is not cleared.
module rgb888_to_rgb555_packetizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import rgbpk_pkg::*;

  // Input side state.
  logic [1:0]  byte_phase;
  logic [6:0]  pixel_index;
  logic [4:0]  red_bits;
  logic [4:0]  green_bits;
  logic [23:0] word_address;

  // Pixel queue.
  pix_entry_t        queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Output run counter: bytes already sent from the head entry.
  logic [3:0] run_cnt;

  logic       in_accept;
  logic       out_accept;
  logic       push;
  logic       pop;
  logic [4:0] top;
  logic       block_end;
  logic [15:0] word;
  pix_entry_t entry_new;
  pix_entry_t head;
  logic [3:0] cur_step;
  logic [3:0] end_step;

  // Request handshakes.
  assign in_stall   = (count == QCNT_W'(QUEUE_DEPTH));
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count != '0);
  assign out_accept = out_valid && !out_stall;

  // Take the top five bits of each colour byte.
  assign top       = in_byte[7:3];
  assign block_end = (pixel_index == 7'(PIXELS - 1));
  // Pack red, green and blue into bits 15:11, 10:6 and 5:1; bit 0 stays clear.
  assign word      = {red_bits, green_bits, top, 1'b0};

  always_comb begin
    entry_new.pix_hi  = word[15:8];
    entry_new.pix_lo  = word[7:0];
    entry_new.opens   = (pixel_index == '0);
    entry_new.closes  = block_end;
    entry_new.address = word_address;
  end

  // A blue byte completes a pixel and queues it.
  assign push = in_accept && (byte_phase == PH_BLUE);

  // Advance the colour phase; an unused phase code is treated as red.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_RED;
      pixel_index  <= '0;
      red_bits     <= '0;
      green_bits   <= '0;
      word_address <= '0;
    end else if (in_accept) begin
      if (byte_phase == PH_GREEN) begin
        green_bits <= top;
        byte_phase <= PH_BLUE;
      end else if (byte_phase == PH_BLUE) begin
        byte_phase <= PH_RED;
        if (block_end) begin
          pixel_index  <= '0;
          word_address <= word_address + 24'(PIXELS);
        end else begin
          pixel_index <= pixel_index + 7'd1;
        end
      end else begin
        red_bits   <= top;
        byte_phase <= PH_GREEN;
      end
    end
  end

  // Queue storage: written at the tail, read at the head.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry_new;
    end
  end

  assign head = queue[rd_ptr];

  // Runs skip the data record unless they open a block, and stop after the
  // pixel unless they close one.
  assign cur_step = run_cnt + (head.opens ? ST_DATA_HDR : ST_PIX_HI);
  assign end_step = head.closes ? ST_LEN_B0 : ST_PIX_LO;
  assign pop      = out_accept && (cur_step == end_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      run_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr  <= rd_ptr + QPTR_W'(1);
        run_cnt <= '0;
      end else if (out_accept) begin
        run_cnt <= run_cnt + 4'd1;
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Select the byte for the current position in the run.
  always_comb begin
    unique case (cur_step)
      ST_DATA_HDR:  out_byte = HDR_DATA;
      ST_DATA_CNT:  out_byte = DATA_COUNT;
      ST_PIX_HI:    out_byte = head.pix_hi;
      ST_PIX_LO:    out_byte = head.pix_lo;
      ST_ADDR_HDR:  out_byte = HDR_ADDRESS;
      ST_ADDR_SIZE: out_byte = REC_SIZE;
      ST_ADDR_B2:   out_byte = head.address[23:16];
      ST_ADDR_B1:   out_byte = head.address[15:8];
      ST_ADDR_B0:   out_byte = head.address[7:0];
      ST_LEN_HDR:   out_byte = HDR_LENGTH;
      ST_LEN_SIZE:  out_byte = REC_SIZE;
      ST_LEN_B2:    out_byte = 8'h00;
      ST_LEN_B1:    out_byte = 8'h00;
      ST_LEN_B0:    out_byte = LEN_COUNT;
      default:      out_byte = 8'h00;
    endcase
  end

  assign last_of_run = (cur_step == end_step);

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("pixel queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && count == QCNT_W'(QUEUE_DEPTH)))
    else $error("pixel queued while queue full");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_step <= end_step))
    else $error("run position past end of run");

  a_run_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> (run_cnt == '0))
    else $error("run counter not restarted after pop");

endmodule

@@ dv/tb.sv @@
// Self-checking bench for the RGB888 to RGB555 packetiser unit.
`timescale 1ns / 1ps
module tb;
  import rgbpk_pkg::*;

  localparam int GROUP_BYTES = 34;    // colour bytes per idling group
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // Predicts the packet byte stream and holds the bytes still to come.
  class packet_board;
    pkt_byte_t   expected_bytes[$];
    logic [1:0]  phase;
    logic [6:0]  pix_index;
    logic [4:0]  red_top;
    logic [4:0]  green_top;
    logic [23:0] word_addr;
    int          errors;

    function new();
      phase     = PH_RED;
      pix_index = '0;
      red_top   = '0;
      green_top = '0;
      word_addr = '0;
      errors    = 0;
    endfunction

    function void push(logic [7:0] data, logic last);
      pkt_byte_t item;
      item.data = data;
      item.last = last;
      expected_bytes.push_back(item);
    endfunction

    // Advance the prediction by one accepted colour byte.
    function void note_request(logic [7:0] colour);
      logic [4:0]  top;
      logic [15:0] word;
      top = colour[7:3];
      case (phase)
        PH_GREEN: begin
          green_top = top;
          phase     = PH_BLUE;
        end
        PH_BLUE: begin
          phase = PH_RED;
          if (pix_index == 0) begin
            push(HDR_DATA, 1'b0);
            push(DATA_COUNT, 1'b0);
          end
          word = {red_top, green_top, top, 1'b0};
          push(word[15:8], 1'b0);
          if (int'(pix_index) + 1 >= PIXELS) begin
            push(word[7:0], 1'b0);
            push(HDR_ADDRESS, 1'b0);
            push(REC_SIZE, 1'b0);
            push(word_addr[23:16], 1'b0);
            push(word_addr[15:8], 1'b0);
            push(word_addr[7:0], 1'b0);
            push(HDR_LENGTH, 1'b0);
            push(REC_SIZE, 1'b0);
            push(8'h00, 1'b0);
            push(8'h00, 1'b0);
            push(LEN_COUNT, 1'b1);
            word_addr = word_addr + 24'(PIXELS);
            pix_index = '0;
          end else begin
            push(word[7:0], 1'b1);
            pix_index = pix_index + 7'd1;
          end
        end
        default: begin
          red_top = top;
          phase   = PH_GREEN;
        end
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic last);
      pkt_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h (last %0b)", data, last));
      end else begin
        want = expected_bytes.pop_front();
        if (data !== want.data)
          report($sformatf("out_byte %02h, want %02h", data, want.data));
        if (last !== want.last)
          report($sformatf("last_of_run %0b, want %0b", last, want.last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_run;

  packet_board board;
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          quiet_cycles;

  rgb888_to_rgb555_packetizer_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one colour byte from a falling edge; return at the falling edge after acceptance.
  task send_byte(input logic [7:0] colour);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= colour;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_request(colour);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(out_byte, last_of_run);
  end

  // End the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] directed_bytes[24];
    int         gap_pct[4];
    int         stall_pct[4];

    directed_bytes = '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
                       8'hf8, 8'h07, 8'hf8, 8'h07, 8'hf8, 8'h07,
                       8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55,
                       8'h80, 8'h08, 8'h10, 8'h7f, 8'h7f, 8'h7f};
    gap_pct   = '{0, 76, 0, 38};
    stall_pct = '{0, 0, 76, 38};

    board          = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes and alternating bit patterns, back to back.
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Random stream over the idling groups; it stops inside a pixel and
    // inside a block at the end.
    for (int g = 0; g < 4; g++) begin
      send_gap_pct   = gap_pct[g];
      recv_stall_pct = stall_pct[g];
      for (int n = 0; n < GROUP_BYTES; n++) begin
        if (g == 0 && n == 10) hold_req = 1'b1;
        send_byte(8'($urandom_range(255)));
      end
    end
    in_valid <= 1'b0;

    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rgbpk_pkg.sv
hdl/rgb888_to_rgb555_packetizer_unit.sv
dv/tb.sv
